// ----- sv/timer_and_interrupt_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the timer and interrupt unit checker
// Expect i_clk and i_rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef TIMER_AND_INTERRUPT_UNIT_ASSERT_SVH
`define TIMER_AND_INTERRUPT_UNIT_ASSERT_SVH

// same-cycle implication
`define TIU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TIU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/tiu_pkg.sv -----
// ----------------------------------------------------------------------------
// tiu_pkg
// Types and constants shared by the timer and interrupt unit modules.
// ----------------------------------------------------------------------------
package tiu_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_TIMER_RELOAD = 2'd0,
        CFG_TIMER_PERIOD = 2'd1,
        CFG_TIMER_STOP   = 2'd2,
        CFG_INT_ENABLE   = 2'd3
    } t_cfg_idx;

    localparam logic [10:0] PERIOD_RESET  = 11'd1024;
    localparam int          TIMER_IRQ_BIT = 2;
    localparam logic [6:0]  VEC_BASE      = 7'h40;
    localparam logic [7:0]  TIMER_MAX     = 8'hff;

    typedef struct packed {
        logic [7:0]  timer_reload;
        logic [10:0] timer_period;
        logic        timer_stopped;
        logic [4:0]  int_enable_mask;
    } t_cfg;

    typedef struct packed {
        logic [7:0] elapsed_cycles;
        logic [4:0] new_requests;
        logic       master_on;
        logic       master_off;
        logic       halt_enter;
    } t_item;

    typedef struct packed {
        logic [7:0] divider_value;
        logic [7:0] timer_value;
        logic [4:0] flags_value;
        logic       take_interrupt;
        logic [6:0] vector_addr;
        logic       halt_wake;
        logic       halted_now;
    } t_result;

    // index of the lowest set bit (highest priority source)
    function automatic logic [2:0] lowest_bit(input logic [4:0] pend);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 4; i >= 0; i--) begin
            if (pend[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [6:0] vector_of(input logic [2:0] idx);
        return 7'(VEC_BASE + {1'b0, idx, 3'b000});
    endfunction

endpackage

// ----- sv/tiu_step.sv -----
// ----------------------------------------------------------------------------
// tiu_step
// Counter, flag and master-enable state; computes one step per request.
// ----------------------------------------------------------------------------
module tiu_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tiu_pkg::t_cfg    i_cfg,
    input  tiu_pkg::t_item   i_item,
    input  logic             i_accept,
    output tiu_pkg::t_result o_result
);

    logic [7:0]  r_div_cnt,  n_div_cnt;
    logic [7:0]  r_div_pre,  n_div_pre;
    logic [7:0]  r_tmr_cnt,  n_tmr_cnt;
    logic [10:0] r_tmr_pre,  n_tmr_pre;
    logic [4:0]  r_flags,    n_flags;
    logic        r_me,       n_me;
    logic        r_ma,       n_ma;
    logic        r_halted,   n_halted;

    logic [8:0]  dsum;
    logic [11:0] tsum;
    logic [10:0] tsum_adj;
    logic [4:0]  pend;
    logic [2:0]  idx;
    logic        take;
    logic        wake;

    always_comb begin
        dsum      = {1'b0, r_div_pre} + {1'b0, i_item.elapsed_cycles};
        n_div_pre = dsum[7:0];
        n_div_cnt = dsum[8] ? r_div_cnt + 8'd1 : r_div_cnt;

        n_flags   = r_flags;
        n_tmr_cnt = r_tmr_cnt;
        n_tmr_pre = r_tmr_pre;
        tsum      = {1'b0, r_tmr_pre} + {4'd0, i_item.elapsed_cycles};
        tsum_adj  = tsum[10:0];
        if (!i_cfg.timer_stopped) begin
            // at most one timer step per request
            if (tsum >= {1'b0, i_cfg.timer_period}) begin
                tsum_adj = 11'(tsum - {1'b0, i_cfg.timer_period});
                if (r_tmr_cnt != tiu_pkg::TIMER_MAX) begin
                    n_tmr_cnt = r_tmr_cnt + 8'd1;
                end else begin
                    n_tmr_cnt = i_cfg.timer_reload;
                    n_flags[tiu_pkg::TIMER_IRQ_BIT] = 1'b1;
                end
            end
            n_tmr_pre = tsum_adj;
        end
        n_flags = n_flags | i_item.new_requests;

        n_me = r_me;
        n_ma = r_ma;
        if (i_item.master_off) begin
            n_me = 1'b0;
            n_ma = 1'b0;
        end else if (i_item.master_on && !r_me) begin
            n_me = 1'b1;
            n_ma = 1'b0;
        end

        n_halted = r_halted | i_item.halt_enter;
        wake     = 1'b0;
        if (n_halted && (n_flags != 5'd0)) begin
            wake     = 1'b1;
            n_halted = 1'b0;
        end

        // enable lags one request: the first enabled request only arms
        pend = n_flags & i_cfg.int_enable_mask;
        idx  = tiu_pkg::lowest_bit(pend);
        take = 1'b0;
        if (n_me) begin
            if (!n_ma) begin
                n_ma = 1'b1;
            end else if (pend != 5'd0) begin
                take         = 1'b1;
                n_flags[idx] = 1'b0;
                n_me         = 1'b0;
                n_ma         = 1'b0;
            end
        end

        o_result.divider_value  = n_div_cnt;
        o_result.timer_value    = n_tmr_cnt;
        o_result.flags_value    = n_flags;
        o_result.take_interrupt = take;
        o_result.vector_addr    = take ? tiu_pkg::vector_of(idx) : 7'd0;
        o_result.halt_wake      = wake;
        o_result.halted_now     = n_halted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
            r_div_pre <= '0;
            r_tmr_cnt <= '0;
            r_tmr_pre <= '0;
            r_flags   <= '0;
            r_me      <= 1'b0;
            r_ma      <= 1'b0;
            r_halted  <= 1'b0;
        end else if (i_accept) begin
            r_div_cnt <= n_div_cnt;
            r_div_pre <= n_div_pre;
            r_tmr_cnt <= n_tmr_cnt;
            r_tmr_pre <= n_tmr_pre;
            r_flags   <= n_flags;
            r_me      <= n_me;
            r_ma      <= n_ma;
            r_halted  <= n_halted;
        end
    end

endmodule

// ----- sv/timer_and_interrupt_unit.sv -----
// ----------------------------------------------------------------------------
// timer_and_interrupt_unit
// Divider, programmable timer and prioritized interrupt dispatch.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------
//   in      | in        | i_in_valid / o_in_stall   | cycles, requests, events
//   out     | out       | o_out_valid / i_out_stall | counters, flags, dispatch
//   cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request per clock while o_in_stall is low; each result is registered.
// The step is one pass of adders, a compare and a priority encoder.
// A two-entry output buffer keeps input flowing while the output is stalled;
// o_in_stall rises only when both entries hold results.
// Reset (synchronous, active low) clears state and loads register defaults.
// ----------------------------------------------------------------------------
module timer_and_interrupt_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_elapsed_cycles,
    input  logic [4:0]  i_new_requests,
    input  logic        i_master_on,
    input  logic        i_master_off,
    input  logic        i_halt_enter,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_divider_value,
    output logic [7:0]  o_timer_value,
    output logic [4:0]  o_flags_value,
    output logic        o_take_interrupt,
    output logic [6:0]  o_vector_addr,
    output logic        o_halt_wake,
    output logic        o_halted_now,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    tiu_pkg::t_cfg    r_cfg;
    tiu_pkg::t_item   item;
    tiu_pkg::t_result step_res;
    tiu_pkg::t_result r_out;
    tiu_pkg::t_result r_skd;
    logic             r_out_v;
    logic             r_skd_v;
    logic             in_acc;
    logic             out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skd_v;
    assign in_acc      = i_in_valid && !r_skd_v;
    assign out_free    = !r_out_v || !i_out_stall;

    assign item.elapsed_cycles = i_elapsed_cycles;
    assign item.new_requests   = i_new_requests;
    assign item.master_on      = i_master_on;
    assign item.master_off     = i_master_off;
    assign item.halt_enter     = i_halt_enter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timer_reload    <= '0;
            r_cfg.timer_period    <= tiu_pkg::PERIOD_RESET;
            r_cfg.timer_stopped   <= 1'b1;
            r_cfg.int_enable_mask <= '0;
        end else if (i_cfg_valid) begin
            unique case (tiu_pkg::t_cfg_idx'(i_cfg_index))
                tiu_pkg::CFG_TIMER_RELOAD: r_cfg.timer_reload    <= i_cfg_data[7:0];
                tiu_pkg::CFG_TIMER_PERIOD: r_cfg.timer_period    <= i_cfg_data;
                tiu_pkg::CFG_TIMER_STOP:   r_cfg.timer_stopped   <= i_cfg_data[0];
                tiu_pkg::CFG_INT_ENABLE:   r_cfg.int_enable_mask <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    tiu_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (item),
        .i_accept (in_acc),
        .o_result (step_res)
    );

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (out_free) begin
            if (r_skd_v) begin
                r_out_v <= 1'b1;
                r_skd_v <= 1'b0;
            end else begin
                r_out_v <= in_acc;
            end
        end else if (in_acc) begin
            r_skd_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skd_v ? r_skd : step_res;
        end else if (in_acc) begin
            r_skd <= step_res;
        end
    end

    assign o_out_valid      = r_out_v;
    assign o_divider_value  = r_out.divider_value;
    assign o_timer_value    = r_out.timer_value;
    assign o_flags_value    = r_out.flags_value;
    assign o_take_interrupt = r_out.take_interrupt;
    assign o_vector_addr    = r_out.vector_addr;
    assign o_halt_wake      = r_out.halt_wake;
    assign o_halted_now     = r_out.halted_now;

endmodule

// ----- sv/tiu_checker.sv -----
// ----------------------------------------------------------------------------
// tiu_checker
// Port-level checks for the timer and interrupt unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "timer_and_interrupt_unit_assert.svh"

module tiu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_timer_value,
    input logic [4:0]  o_flags_value,
    input logic        o_take_interrupt,
    input logic [6:0]  o_vector_addr,
    input logic        o_halt_wake,
    input logic        o_halted_now
);

    // a dispatch always carries one of the five vectors
    `TIU_ASSERT_NOW(a_take_vec, o_out_valid && o_take_interrupt,
        o_vector_addr == 7'h40 || o_vector_addr == 7'h48 || o_vector_addr == 7'h50 ||
        o_vector_addr == 7'h58 || o_vector_addr == 7'h60, "dispatch without valid vector")

    `TIU_ASSERT_NOW(a_no_take_vec, o_out_valid && !o_take_interrupt,
        o_vector_addr == 7'd0, "vector set without dispatch")

    // a pending flag always ends the halt before dispatch
    `TIU_ASSERT_NOW(a_take_awake, o_out_valid && (o_take_interrupt || o_halt_wake),
        !o_halted_now, "still halted after wake or dispatch")

    `TIU_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_timer_value) && $stable(o_flags_value),
        "stalled result changed")

endmodule

bind timer_and_interrupt_unit tiu_checker u_tiu_checker (.*);
